/* design/mwdc_pkg.sv */
// Shared types, codes and helpers of the mecanum waypoint drive controller.
package mwdc_pkg;

  // Configuration port widths
  localparam int CFG_W  = 20;
  localparam int CFG_IW = 3;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_ODO_TOL   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SONAR_TOL = 3'd1;
  localparam logic [CFG_IW-1:0] REG_YAW_TH    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_YAW_DIV   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_YAW_LIM   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MIN_SPD   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_FORCE     = 3'd6;

  // Actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_MOVE  = 2'd1;
  localparam logic [1:0] ACT_SONAR = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // Motor commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Target modes
  localparam logic [2:0] MODE_ODO = 3'd0;
  localparam logic [2:0] MODE_FR  = 3'd1;
  localparam logic [2:0] MODE_RB  = 3'd2;
  localparam logic [2:0] MODE_BL  = 3'd3;

  // Fixed tuning constants
  localparam logic signed [15:0] GYRO_DEAD = 16'sd5;
  localparam logic [13:0] ODO_OFS   = 14'd500;
  localparam logic [13:0] ODO_KNEE  = 14'd600;
  localparam logic [13:0] SONAR_OFS = 14'd400;
  localparam logic [7:0]  SONAR_BIAS = 8'd3;
  localparam logic [7:0]  FAC_STEP  = 8'd100;
  localparam logic [2:0]  YAW_STEP  = 3'd5;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] enc_left_front;
    logic signed [15:0] enc_right_front;
    logic signed [15:0] enc_left_back;
    logic signed [15:0] enc_right_back;
    logic [2:0]         move_mode;
    logic [13:0]        move_speed;
    logic signed [31:0] target_first;
    logic signed [31:0] target_second;
    logic [1:0]         sonar_index;
    logic [15:0]        sonar_distance;
  } mwdc_in_t;

  typedef struct packed {
    logic [1:0]         motor_command;
    logic signed [15:0] wheel_left_front;
    logic signed [15:0] wheel_right_front;
    logic signed [15:0] wheel_left_back;
    logic signed [15:0] wheel_right_back;
    logic               is_running;
    logic signed [31:0] odometry_x;
    logic signed [31:0] odometry_y;
  } mwdc_out_t;

  // Saturate an 18-bit signed setpoint to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] res;
    if (v > 18'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

/* design/mecanum_waypoint_drive_controller.sv */
// Move, sonar update and clear go straight to the finish state to give their beat.
// A tick may run the one-bit-per-cycle shift-add multiplier, root unit and long
// divider; the other items skip them.
// One item is in work at a time; the next is taken when the result is handed on.
// Sync active-low reset (rst_n) clears architectural state, loads register defaults.
// Top level: yaw correction, odometry, error root and mecanum wheel mixing.
module mecanum_waypoint_drive_controller #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mwdc_pkg::mwdc_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mwdc_pkg::mwdc_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [mwdc_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [mwdc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int RW = 32 + FRAC_BITS;   // root width
  localparam int DW = 46 + FRAC_BITS;   // divider dividend width
  localparam int CW = 7;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_ROT      = 5'd1;
  localparam logic [4:0] ST_ROT_DIV  = 5'd2;
  localparam logic [4:0] ST_ERR      = 5'd3;
  localparam logic [4:0] ST_SQX      = 5'd4;
  localparam logic [4:0] ST_SQY      = 5'd5;
  localparam logic [4:0] ST_ROOT     = 5'd6;
  localparam logic [4:0] ST_FAC_DIV  = 5'd7;
  localparam logic [4:0] ST_BOUND    = 5'd8;
  localparam logic [4:0] ST_APP_MUL  = 5'd9;
  localparam logic [4:0] ST_APP_DIV  = 5'd10;
  localparam logic [4:0] ST_CX_MUL   = 5'd11;
  localparam logic [4:0] ST_CX_DIV   = 5'd12;
  localparam logic [4:0] ST_CY_MUL   = 5'd13;
  localparam logic [4:0] ST_CY_DIV   = 5'd14;
  localparam logic [4:0] ST_MIX      = 5'd15;
  localparam logic [4:0] ST_FIN      = 5'd16;

  // Configuration registers
  logic [15:0] otol_r, otol_nxt, stol_r, stol_nxt, ydiv_r, ydiv_nxt;
  logic [19:0] yth_r, yth_nxt;
  logic [7:0]  ylim_r, ylim_nxt, fticks_r, fticks_nxt;
  logic [13:0] smin_r, smin_nxt;

  // Architectural state
  logic [31:0] yaw_r, yaw_nxt, px_r, px_nxt, py_r, py_nxt, gx_r, gx_nxt, gy_r, gy_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  fc_r, fc_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [13:0] cruise_r, cruise_nxt;
  logic [15:0] wgoal_r [4];
  logic [15:0] wgoal_nxt [4];
  logic [15:0] wnow_r [4];
  logic [15:0] wnow_nxt [4];

  // Sequencer and work registers
  logic [4:0]         st_r, st_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               fcnz_r, fcnz_nxt, ysgn_r, ysgn_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [8:0]  rot_r, rot_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [31:0]        ax_r, ax_nxt, ay_r, ay_nxt;
  logic [13:0]        mspd_r, mspd_nxt;
  logic signed [15:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic signed [15:0] wh_r [4];
  logic signed [15:0] wh_nxt [4];

  // Shift-add multiplier, also the radicand shifter of the root unit
  logic [63:0]        acc_r, acc_nxt, mc_r, mc_nxt;
  logic [31:0]        mp_r, mp_nxt;
  // Restoring divider
  logic [DW-1:0]      dq_r, dq_nxt;
  logic [RW-1:0]      drem_r, drem_nxt, dvs_r, dvs_nxt;
  // Root unit
  logic [RW+1:0]      srem_r, srem_nxt;
  logic [RW-1:0]      root_r, root_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  mwdc_pkg::mwdc_out_t out_r, out_nxt;

  // Step results of the serial units
  logic [63:0]   acc_step;
  logic [RW:0]   dv_t;
  logic          dv_ge;
  logic [RW-1:0] drem_step;
  logic [DW-1:0] dq_step;
  logic [RW+3:0] sq_x, sq_trial;
  logic          sq_ge;
  logic [RW+1:0] srem_step;
  logic [RW-1:0] root_step;
  logic          last;

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign last      = (cnt_r == CW'(1));

  // One multiplier bit, one quotient bit and one root bit per cycle
  always_comb begin
    acc_step  = acc_r + (mp_r[0] ? mc_r : 64'd0);
    dv_t      = {drem_r, dq_r[DW-1]};
    dv_ge     = (dv_t >= {1'b0, dvs_r});
    drem_step = dv_ge ? RW'(dv_t - {1'b0, dvs_r}) : dv_t[RW-1:0];
    dq_step   = {dq_r[DW-2:0], dv_ge};
    sq_x      = {srem_r, acc_r[63:62]};
    sq_trial  = {2'b00, root_r, 2'b01};
    sq_ge     = (sq_x >= sq_trial);
    srem_step = sq_ge ? (RW+2)'(sq_x - sq_trial) : sq_x[RW+1:0];
    root_step = {root_r[RW-2:0], sq_ge};
  end

  always_comb begin
    logic               odo;
    logic signed [31:0] dx, dy;
    logic [31:0]        ymag;
    logic [31:0]        q32;
    logic [7:0]         qc, fac;
    logic [23:0]        bound;
    logic [12:0]        half;
    logic               start_comp;
    logic [13:0]        ms;
    logic [15:0]        qv;
    logic signed [17:0] w1, w2, c, ewx, ewy;
    logic signed [8:0]  rot_v;

    otol_nxt = otol_r; stol_nxt = stol_r; yth_nxt = yth_r; ydiv_nxt = ydiv_r;
    ylim_nxt = ylim_r; smin_nxt = smin_r; fticks_nxt = fticks_r;
    yaw_nxt = yaw_r; px_nxt = px_r; py_nxt = py_r; gx_nxt = gx_r; gy_nxt = gy_r;
    run_nxt = run_r; fc_nxt = fc_r; mode_nxt = mode_r; cruise_nxt = cruise_r;
    for (int i = 0; i < 4; i++) begin
      wgoal_nxt[i] = wgoal_r[i];
      wnow_nxt[i]  = wnow_r[i];
      wh_nxt[i]    = wh_r[i];
    end
    st_nxt = st_r; cnt_nxt = cnt_r; fcnz_nxt = fcnz_r; ysgn_nxt = ysgn_r;
    sx_nxt = sx_r; sy_nxt = sy_r; rot_nxt = rot_r; cmd_nxt = cmd_r;
    ax_nxt = ax_r; ay_nxt = ay_r; mspd_nxt = mspd_r; wx_nxt = wx_r; wy_nxt = wy_r;
    acc_nxt = acc_r; mc_nxt = mc_r; mp_nxt = mp_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dvs_nxt = dvs_r;
    srem_nxt = srem_r; root_nxt = root_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    odo = (mode_r == mwdc_pkg::MODE_ODO);
    dx = '0; dy = '0; ymag = '0; q32 = '0; qc = '0; fac = '0; bound = '0;
    half = cruise_r[13:1];
    start_comp = 1'b0; ms = '0; qv = '0;
    w1 = '0; w2 = '0; c = '0; ewx = '0; ewy = '0; rot_v = '0;

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        mwdc_pkg::REG_ODO_TOL:   otol_nxt   = cfg_data[15:0];
        mwdc_pkg::REG_SONAR_TOL: stol_nxt   = cfg_data[15:0];
        mwdc_pkg::REG_YAW_TH:    yth_nxt    = cfg_data[19:0];
        mwdc_pkg::REG_YAW_DIV:   ydiv_nxt   = cfg_data[15:0];
        mwdc_pkg::REG_YAW_LIM:   ylim_nxt   = cfg_data[7:0];
        mwdc_pkg::REG_MIN_SPD:   smin_nxt   = cfg_data[13:0];
        mwdc_pkg::REG_FORCE:     fticks_nxt = cfg_data[7:0];
        default: ;
      endcase
    end

    // Serial unit stepping in their own states
    if (st_r == ST_SQX || st_r == ST_SQY || st_r == ST_APP_MUL ||
        st_r == ST_CX_MUL || st_r == ST_CY_MUL) begin
      acc_nxt = acc_step;
      mc_nxt  = {mc_r[62:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[31:1]};
      cnt_nxt = cnt_r - CW'(1);
    end
    if (st_r == ST_ROT_DIV || st_r == ST_FAC_DIV || st_r == ST_APP_DIV ||
        st_r == ST_CX_DIV || st_r == ST_CY_DIV) begin
      dq_nxt   = dq_step;
      drem_nxt = drem_step;
      cnt_nxt  = cnt_r - CW'(1);
    end
    if (st_r == ST_ROOT) begin
      acc_nxt  = {acc_r[61:0], 2'b00};
      srem_nxt = srem_step;
      root_nxt = root_step;
      cnt_nxt  = cnt_r - CW'(1);
    end

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = mwdc_pkg::CMD_NONE;
          for (int i = 0; i < 4; i++) wh_nxt[i] = '0;
          st_nxt = ST_FIN;
          case (in_data.action)
            mwdc_pkg::ACT_TICK: begin
              // Integrate yaw, odometry and the forced-run countdown
              if (in_data.gyro_rate > mwdc_pkg::GYRO_DEAD ||
                  in_data.gyro_rate < -mwdc_pkg::GYRO_DEAD) begin
                yaw_nxt = yaw_r + {{16{in_data.gyro_rate[15]}}, in_data.gyro_rate};
              end
              px_nxt = px_r + {{16{in_data.enc_left_back[15]}}, in_data.enc_left_back}
                            - {{16{in_data.enc_right_back[15]}}, in_data.enc_right_back}
                            + {{16{in_data.enc_right_front[15]}}, in_data.enc_right_front}
                            - {{16{in_data.enc_left_front[15]}}, in_data.enc_left_front};
              py_nxt = py_r + {{16{in_data.enc_left_back[15]}}, in_data.enc_left_back}
                            + {{16{in_data.enc_left_front[15]}}, in_data.enc_left_front}
                            + {{16{in_data.enc_right_back[15]}}, in_data.enc_right_back}
                            + {{16{in_data.enc_right_front[15]}}, in_data.enc_right_front};
              fcnz_nxt = (fc_r != 8'd0);
              run_nxt  = run_r || (fc_r != 8'd0);
              fc_nxt   = (fc_r != 8'd0) ? fc_r - 8'd1 : fc_r;
              cmd_nxt  = mwdc_pkg::CMD_STOP;
              st_nxt   = ST_ROT;
            end
            mwdc_pkg::ACT_MOVE: begin
              mode_nxt   = in_data.move_mode;
              fc_nxt     = fticks_r;
              run_nxt    = 1'b1;
              cruise_nxt = in_data.move_speed;
              case (in_data.move_mode)
                mwdc_pkg::MODE_ODO: begin
                  gx_nxt = in_data.target_first;
                  gy_nxt = in_data.target_second;
                end
                mwdc_pkg::MODE_FR: begin
                  wgoal_nxt[0] = in_data.target_first[15:0];
                  wgoal_nxt[1] = in_data.target_second[15:0];
                end
                mwdc_pkg::MODE_RB: begin
                  wgoal_nxt[1] = in_data.target_first[15:0];
                  wgoal_nxt[2] = in_data.target_second[15:0];
                end
                mwdc_pkg::MODE_BL: begin
                  wgoal_nxt[2] = in_data.target_first[15:0];
                  wgoal_nxt[3] = in_data.target_second[15:0];
                end
                default: begin
                  wgoal_nxt[3] = in_data.target_first[15:0];
                  wgoal_nxt[0] = in_data.target_second[15:0];
                end
              endcase
            end
            mwdc_pkg::ACT_SONAR: begin
              wnow_nxt[in_data.sonar_index] = in_data.sonar_distance;
            end
            default: begin
              yaw_nxt = '0; px_nxt = '0; py_nxt = '0; gx_nxt = '0; gy_nxt = '0;
              run_nxt = 1'b0; fc_nxt = '0; mode_nxt = mwdc_pkg::MODE_ODO; cruise_nxt = '0;
              for (int i = 0; i < 4; i++) begin
                wgoal_nxt[i] = '0;
                wnow_nxt[i]  = '0;
              end
            end
          endcase
        end
      end

      // Start the yaw correction division when outside the threshold
      ST_ROT: begin
        ymag     = yaw_r[31] ? (32'd0 - yaw_r) : yaw_r;
        ysgn_nxt = yaw_r[31];
        rot_nxt  = '0;
        if (ymag > {12'd0, yth_r}) begin
          dq_nxt   = DW'(ymag - {12'd0, yth_r}) << (DW - 32);
          drem_nxt = '0;
          dvs_nxt  = RW'((ydiv_r == 16'd0) ? 16'd1 : ydiv_r);
          cnt_nxt  = CW'(32);
          st_nxt   = ST_ROT_DIV;
        end else begin
          st_nxt = ST_ERR;
        end
      end

      ST_ROT_DIV: begin
        if (last) begin
          q32 = dq_step[31:0];
          qc  = (q32 > {24'd0, ylim_r}) ? ylim_r : q32[7:0];
          rot_nxt = ysgn_r ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
          st_nxt  = ST_ERR;
        end
      end

      // When running, form the position error and start squaring, else finish
      ST_ERR: begin
        if (!run_r) begin
          st_nxt = ST_FIN;
        end else begin
          if (odo) begin
            dx = $signed(gx_r - px_r);
            dy = $signed(gy_r - py_r);
          end else begin
            case (mode_r)
              mwdc_pkg::MODE_FR: begin
                dx = 32'($signed({1'b0, wgoal_r[1]}) - $signed({1'b0, wnow_r[1]}));
                dy = 32'($signed({1'b0, wnow_r[0]}) - $signed({1'b0, wgoal_r[0]}));
              end
              mwdc_pkg::MODE_RB: begin
                dx = 32'($signed({1'b0, wgoal_r[1]}) - $signed({1'b0, wnow_r[1]}));
                dy = 32'($signed({1'b0, wgoal_r[2]}) - $signed({1'b0, wnow_r[2]}));
              end
              mwdc_pkg::MODE_BL: begin
                dx = 32'($signed({1'b0, wnow_r[3]}) - $signed({1'b0, wgoal_r[3]}));
                dy = 32'($signed({1'b0, wgoal_r[2]}) - $signed({1'b0, wnow_r[2]}));
              end
              default: begin
                dx = 32'($signed({1'b0, wnow_r[3]}) - $signed({1'b0, wgoal_r[3]}));
                dy = 32'($signed({1'b0, wnow_r[0]}) - $signed({1'b0, wgoal_r[0]}));
              end
            endcase
          end
          sx_nxt  = dx[31];
          sy_nxt  = dy[31];
          ax_nxt  = dx[31] ? (32'd0 - dx) : dx;
          ay_nxt  = dy[31] ? (32'd0 - dy) : dy;
          acc_nxt = '0;
          mc_nxt  = {32'd0, ax_nxt};
          mp_nxt  = ax_nxt;
          cnt_nxt = CW'(32);
          st_nxt  = ST_SQX;
        end
      end

      ST_SQX: begin
        if (last) begin
          mc_nxt  = {32'd0, ay_r};
          mp_nxt  = ay_r;
          cnt_nxt = CW'(32);
          st_nxt  = ST_SQY;
        end
      end

      ST_SQY: begin
        if (last) begin
          srem_nxt = '0;
          root_nxt = '0;
          cnt_nxt  = CW'(RW);
          st_nxt   = ST_ROOT;
        end
      end

      // After the root, divide the speed offset into factor steps
      ST_ROOT: begin
        if (last) begin
          if (odo) begin
            dq_nxt = DW'((cruise_r >= mwdc_pkg::ODO_OFS) ? cruise_r - mwdc_pkg::ODO_OFS
                                                          : 14'd0) << (DW - 14);
          end else begin
            dq_nxt = DW'((cruise_r >= mwdc_pkg::SONAR_OFS) ? cruise_r - mwdc_pkg::SONAR_OFS
                                                            : 14'd0) << (DW - 14);
          end
          drem_nxt = '0;
          dvs_nxt  = RW'(mwdc_pkg::FAC_STEP);
          cnt_nxt  = CW'(14);
          st_nxt   = ST_FAC_DIV;
        end
      end

      ST_FAC_DIV: begin
        if (last) st_nxt = ST_BOUND;
      end

      // Stop inside the tolerance radius unless a forced run counts, else pick the speed
      ST_BOUND: begin
        if (odo) begin
          fac   = (cruise_r >= mwdc_pkg::ODO_KNEE) ? dq_r[7:0] : 8'd1;
          bound = otol_r * fac;
        end else begin
          fac   = (cruise_r >= mwdc_pkg::SONAR_OFS && dq_r[7:0] > mwdc_pkg::SONAR_BIAS)
                  ? dq_r[7:0] - mwdc_pkg::SONAR_BIAS : 8'd1;
          bound = stol_r * fac;
        end
        if (root_r <= RW'({bound, {FRAC_BITS{1'b0}}}) && !fcnz_r) begin
          run_nxt = 1'b0;
          st_nxt  = ST_FIN;
        end else if (odo) begin
          ms = cruise_r;
          start_comp = 1'b1;
        end else if (half != 13'd0 && root_r < RW'({half, {FRAC_BITS{1'b0}}})) begin
          acc_nxt = '0;
          mc_nxt  = 64'(root_r);
          mp_nxt  = {18'd0, cruise_r};
          cnt_nxt = CW'(14);
          st_nxt  = ST_APP_MUL;
        end else begin
          ms = (cruise_r < smin_r) ? smin_r : cruise_r;
          start_comp = 1'b1;
        end
      end

      ST_APP_MUL: begin
        if (last) begin
          dq_nxt   = DW'(acc_step[FRAC_BITS+31:FRAC_BITS]) << (DW - 32);
          drem_nxt = '0;
          dvs_nxt  = RW'(half);
          cnt_nxt  = CW'(32);
          st_nxt   = ST_APP_DIV;
        end
      end

      ST_APP_DIV: begin
        if (last) begin
          ms = (dq_step[13:0] < smin_r) ? smin_r : dq_step[13:0];
          start_comp = 1'b1;
        end
      end

      ST_CX_MUL: begin
        if (last) begin
          dq_nxt   = {acc_step[45:0], {FRAC_BITS{1'b0}}};
          drem_nxt = '0;
          dvs_nxt  = root_r;
          cnt_nxt  = CW'(DW);
          st_nxt   = ST_CX_DIV;
        end
      end

      ST_CX_DIV: begin
        if (last) begin
          qv      = dq_step[15:0];
          wx_nxt  = sx_r ? -$signed(qv) : $signed(qv);
          acc_nxt = '0;
          mc_nxt  = {32'd0, ay_r};
          mp_nxt  = {18'd0, mspd_r};
          cnt_nxt = CW'(14);
          st_nxt  = ST_CY_MUL;
        end
      end

      ST_CY_MUL: begin
        if (last) begin
          dq_nxt   = {acc_step[45:0], {FRAC_BITS{1'b0}}};
          drem_nxt = '0;
          dvs_nxt  = root_r;
          cnt_nxt  = CW'(DW);
          st_nxt   = ST_CY_DIV;
        end
      end

      ST_CY_DIV: begin
        if (last) begin
          qv     = dq_step[15:0];
          wy_nxt = sy_r ? -$signed(qv) : $signed(qv);
          st_nxt = ST_MIX;
        end
      end

      // Mix mecanum setpoints with the yaw correction
      ST_MIX: begin
        ewx   = 18'(wx_r);
        ewy   = 18'(wy_r);
        rot_v = rot_r;
        c     = 18'(rot_v) * $signed({15'd0, mwdc_pkg::YAW_STEP});
        w1    = ewy - ewx;
        w2    = ewy + ewx;
        wh_nxt[0] = mwdc_pkg::sat16(w1 - c);
        wh_nxt[1] = mwdc_pkg::sat16(w2 + c);
        wh_nxt[2] = mwdc_pkg::sat16(w2 - c);
        wh_nxt[3] = mwdc_pkg::sat16(w1 + c);
        cmd_nxt   = mwdc_pkg::CMD_SET;
        st_nxt    = ST_FIN;
      end

      // Hand the beat to the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.motor_command     = cmd_r;
          out_nxt.wheel_left_front  = wh_r[0];
          out_nxt.wheel_right_front = wh_r[1];
          out_nxt.wheel_left_back   = wh_r[2];
          out_nxt.wheel_right_back  = wh_r[3];
          out_nxt.is_running        = run_r;
          out_nxt.odometry_x        = px_r;
          out_nxt.odometry_y        = py_r;
          out_valid_nxt             = 1'b1;
          st_nxt                    = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase

    // Launch the first component: zero distance gives zero components
    if (start_comp) begin
      mspd_nxt = ms;
      if (root_r == '0) begin
        wx_nxt = '0;
        wy_nxt = '0;
        st_nxt = ST_MIX;
      end else begin
        acc_nxt = '0;
        mc_nxt  = {32'd0, ax_r};
        mp_nxt  = {18'd0, ms};
        cnt_nxt = CW'(14);
        st_nxt  = ST_CX_MUL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      otol_r <= 16'd100; stol_r <= 16'd20; yth_r <= 20'd1500; ydiv_r <= 16'd500;
      ylim_r <= 8'd20; smin_r <= 14'd200; fticks_r <= 8'd20;
      yaw_r <= '0; px_r <= '0; py_r <= '0; gx_r <= '0; gy_r <= '0;
      run_r <= 1'b0; fc_r <= '0; mode_r <= mwdc_pkg::MODE_ODO; cruise_r <= '0;
      for (int i = 0; i < 4; i++) begin
        wgoal_r[i] <= '0;
        wnow_r[i]  <= '0;
      end
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      otol_r <= otol_nxt; stol_r <= stol_nxt; yth_r <= yth_nxt; ydiv_r <= ydiv_nxt;
      ylim_r <= ylim_nxt; smin_r <= smin_nxt; fticks_r <= fticks_nxt;
      yaw_r <= yaw_nxt; px_r <= px_nxt; py_r <= py_nxt; gx_r <= gx_nxt; gy_r <= gy_nxt;
      run_r <= run_nxt; fc_r <= fc_nxt; mode_r <= mode_nxt; cruise_r <= cruise_nxt;
      for (int i = 0; i < 4; i++) begin
        wgoal_r[i] <= wgoal_nxt[i];
        wnow_r[i]  <= wnow_nxt[i];
      end
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Work and payload registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt; fcnz_r <= fcnz_nxt; ysgn_r <= ysgn_nxt; sx_r <= sx_nxt;
    sy_r <= sy_nxt; rot_r <= rot_nxt; cmd_r <= cmd_nxt; ax_r <= ax_nxt; ay_r <= ay_nxt;
    mspd_r <= mspd_nxt; wx_r <= wx_nxt; wy_r <= wy_nxt;
    for (int i = 0; i < 4; i++) wh_r[i] <= wh_nxt[i];
    acc_r <= acc_nxt; mc_r <= mc_nxt; mp_r <= mp_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dvs_r <= dvs_nxt;
    srem_r <= srem_nxt; root_r <= root_nxt;
    out_r <= out_nxt;
  end

endmodule
